/* rtl/core/vsb_pkg.sv */
// ----------------------------------------------------------------------------
// vsb_pkg: shared definitions of the vertical symmetric blur
// Sizes, register indexes and the types passed between the delay line, the
// lane cores and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package vsb_pkg;

   localparam int LANES     = 8;
   localparam int MAX_TAPS  = 8;
   localparam int MIN_TAPS  = 4;
   localparam int DEPTH     = 2 * MAX_TAPS;
   localparam int WIN       = DEPTH + 1;
   localparam int SAMPLE_W  = 15;
   localparam int OUT_W     = 16;
   localparam int COEF_W    = 16;
   localparam int ACC_W     = 32;
   localparam int FRAC_W    = 16;
   localparam int PAIR_W    = SAMPLE_W + 2;
   localparam int PROD_W    = PAIR_W + COEF_W;
   localparam int PARTS     = (MAX_TAPS + 1) / 2;
   localparam int TAP_W     = $clog2(MAX_TAPS + 1);
   localparam int FLUSH_W   = $clog2(DEPTH + 1);
   localparam int TAP_REG_W = 4;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 2;
   localparam int REG_COEFS = CSR_W / COEF_W;

   localparam logic [ACC_W-1:0] ROUND = ACC_W'(32'h8000);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TAP_COUNT  = 2'd0,
      REG_COEF_LOW   = 2'd1,
      REG_COEF_HIGH  = 2'd2
   } csr_index_type;

   typedef logic [LANES-1:0][SAMPLE_W-1:0]          row_type;
   typedef logic [WIN-1:0][LANES-1:0][SAMPLE_W-1:0] window_type;
   typedef logic [WIN-1:0][SAMPLE_W-1:0]            column_type;
   typedef logic [MAX_TAPS-1:0][COEF_W-1:0]         coef_type;

   typedef struct packed {
      logic             advance;
      logic [TAP_W-1:0] taps;
   } ctrl_type;

   typedef struct packed {
      logic live;
      logic last;
   } row_status_type;

endpackage

`default_nettype wire

/* rtl/core/vsb_history.sv */
// ----------------------------------------------------------------------------
// vsb_history: row delay line and flush sequencer
// Holds the last 2*MAX_TAPS rows, presents the full window of the row being
// issued and inserts zero rows after the last row of a column.
// ----------------------------------------------------------------------------
`default_nettype none

module vsb_history
   import vsb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire ctrl_type       ctrl,
   input  wire logic           req_valid,
   input  wire row_type        req_row,
   input  wire logic           req_last_row,
   output logic                req_ready,
   output window_type          window,
   output row_status_type      status
);

   logic [DEPTH-1:0][LANES-1:0][SAMPLE_W-1:0] hist_ff, hist_in;
   logic [FLUSH_W-1:0] flush_ff, flush_in;
   logic               flushing;
   logic               step;
   row_type            cur;

   assign flushing    = (flush_ff != '0);
   // No word is taken while reset is held.
   assign req_ready   = !reset && ctrl.advance && !flushing;
   assign cur         = flushing ? '0 : req_row;
   assign window      = {hist_ff, cur};
   assign status.live = flushing || req_valid;
   assign status.last = flushing && (flush_ff == FLUSH_W'(1));
   assign step        = ctrl.advance && status.live;

   always_comb begin
      hist_in  = hist_ff;
      flush_in = flush_ff;
      if (step) begin
         // The final flush row leaves the whole line zero for the next column.
         if (status.last) begin
            hist_in = '0;
         end else begin
            hist_in = {hist_ff[DEPTH-2:0], cur};
         end
         if (flushing) begin
            flush_in = flush_ff - FLUSH_W'(1);
         end else if (req_last_row) begin
            flush_in = FLUSH_W'({ctrl.taps, 1'b0});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         flush_ff <= '0;
      end else begin
         hist_ff  <= hist_in;
         flush_ff <= flush_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/vsb_lane.sv */
// ----------------------------------------------------------------------------
// vsb_lane: filter core of one lane
// Three register stages: folded tap pairs, coefficient products, partial
// sums. Rounding, the centre add and saturation follow combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module vsb_lane
   import vsb_pkg::*;
(
   input  wire logic        clock,
   input  wire ctrl_type    ctrl,
   input  wire column_type  column,
   input  wire coef_type    coefs,
   output logic [OUT_W-1:0] result
);

   logic signed [PAIR_W-1:0] pair_ff [MAX_TAPS];
   logic signed [PAIR_W-1:0] pair_in [MAX_TAPS];
   logic signed [PROD_W-1:0] full_prod [MAX_TAPS];
   logic [ACC_W-1:0]         prod_ff [MAX_TAPS];
   logic [ACC_W-1:0]         part_ff [PARTS];
   logic [ACC_W-1:0]         part_in [PARTS];
   logic [SAMPLE_W-1:0]      centre_a_ff, centre_b_ff, centre_c_ff, centre_in;
   logic [ACC_W-1:0]         acc;
   logic [OUT_W-1:0]         hi;
   logic [OUT_W:0]           sum;

   // Both rows of a pair share the coefficient, so they are folded first:
   // (above - c) + (below - c) = above + below - 2c. Taps beyond n read zero.
   always_comb begin
      centre_in = '0;
      for (int i = 0; i < MAX_TAPS; i++) begin
         pair_in[i] = '0;
      end
      for (int k = MIN_TAPS; k <= MAX_TAPS; k++) begin
         if (ctrl.taps == TAP_W'(k)) begin
            centre_in = column[k];
            for (int i = 1; i <= k; i++) begin
               pair_in[i-1] = $signed({2'b00, column[k+i]})
                            + $signed({2'b00, column[k-i]})
                            - $signed({1'b0, column[k], 1'b0});
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_TAPS; i++) begin
         full_prod[i] = pair_ff[i] * $signed(coefs[i]);
      end
      for (int p = 0; p < PARTS; p++) begin
         if (2 * p + 1 < MAX_TAPS) begin
            part_in[p] = prod_ff[2*p] + prod_ff[2*p+1];
         end else begin
            part_in[p] = prod_ff[2*p];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            pair_ff[i] <= pair_in[i];
            prod_ff[i] <= full_prod[i][ACC_W-1:0];
         end
         for (int p = 0; p < PARTS; p++) begin
            part_ff[p] <= part_in[p];
         end
         centre_a_ff <= centre_in;
         centre_b_ff <= centre_a_ff;
         centre_c_ff <= centre_b_ff;
      end
   end

   always_comb begin
      acc = ROUND;
      for (int p = 0; p < PARTS; p++) begin
         acc = acc + part_ff[p];
      end
      hi  = acc[ACC_W-1:FRAC_W];
      sum = {2'b00, centre_c_ff} + {hi[OUT_W-1], hi};
      // The two top bits disagree only when the signed sum left 16 bits.
      if (!sum[OUT_W] && sum[OUT_W-1]) begin
         result = {1'b0, {(OUT_W-1){1'b1}}};
      end else if (sum[OUT_W] && !sum[OUT_W-1]) begin
         result = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         result = sum[OUT_W-1:0];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/vertical_symmetric_blur.sv */
// ----------------------------------------------------------------------------
// vertical_symmetric_blur: vertical symmetric FIR blur over an 8-lane column
// Pipeline: an accepted word passes four registers (window fold, multiply,
//   partial sum, output register) before it shows on rsp_*.
// Throughput: one row per cycle while rsp_ready keeps the pipeline moving;
//   a last row adds 2n flush rows, one per cycle, with req_ready low meanwhile.
// Reset clears the delay line, flush counter, valid flags and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vertical_symmetric_blur
   import vsb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [SAMPLE_W-1:0]   req_lane_in_0,
   input  wire logic [SAMPLE_W-1:0]   req_lane_in_1,
   input  wire logic [SAMPLE_W-1:0]   req_lane_in_2,
   input  wire logic [SAMPLE_W-1:0]   req_lane_in_3,
   input  wire logic [SAMPLE_W-1:0]   req_lane_in_4,
   input  wire logic [SAMPLE_W-1:0]   req_lane_in_5,
   input  wire logic [SAMPLE_W-1:0]   req_lane_in_6,
   input  wire logic [SAMPLE_W-1:0]   req_lane_in_7,
   input  wire logic                  req_last_row,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [OUT_W-1:0]    rsp_lane_out_0,
   output logic signed [OUT_W-1:0]    rsp_lane_out_1,
   output logic signed [OUT_W-1:0]    rsp_lane_out_2,
   output logic signed [OUT_W-1:0]    rsp_lane_out_3,
   output logic signed [OUT_W-1:0]    rsp_lane_out_4,
   output logic signed [OUT_W-1:0]    rsp_lane_out_5,
   output logic signed [OUT_W-1:0]    rsp_lane_out_6,
   output logic signed [OUT_W-1:0]    rsp_lane_out_7,
   output logic                       rsp_column_end
);

   logic [TAP_REG_W-1:0] tap_ff, tap_in;
   logic [CSR_W-1:0]     coef_low_ff, coef_low_in;
   logic [CSR_W-1:0]     coef_high_ff, coef_high_in;
   logic [TAP_W-1:0]     taps_eff;
   coef_type             coefs;
   ctrl_type             ctrl;
   row_type              req_row;
   window_type           window;
   row_status_type       status;
   column_type           column [LANES];
   logic [OUT_W-1:0]     lane_result [LANES];
   logic [OUT_W-1:0]     out_ff [LANES];
   logic                 va_ff, vb_ff, vc_ff, out_valid_ff;
   logic                 ea_ff, eb_ff, ec_ff, out_end_ff;

   // Configuration registers.
   always_comb begin
      tap_in       = tap_ff;
      coef_low_in  = coef_low_ff;
      coef_high_in = coef_high_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_TAP_COUNT: tap_in       = csr_wdata[TAP_REG_W-1:0];
            REG_COEF_LOW:  coef_low_in  = csr_wdata;
            REG_COEF_HIGH: coef_high_in = csr_wdata;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff       <= TAP_REG_W'(MIN_TAPS);
         coef_low_ff  <= '0;
         coef_high_ff <= '0;
      end else begin
         tap_ff       <= tap_in;
         coef_low_ff  <= coef_low_in;
         coef_high_ff <= coef_high_in;
      end
   end

   always_comb begin
      if (int'(tap_ff) < MIN_TAPS) begin
         taps_eff = TAP_W'(MIN_TAPS);
      end else if (int'(tap_ff) > MAX_TAPS) begin
         taps_eff = TAP_W'(MAX_TAPS);
      end else begin
         taps_eff = TAP_W'(tap_ff);
      end
      for (int i = 0; i < MAX_TAPS; i++) begin
         if (i < REG_COEFS) begin
            coefs[i] = coef_low_ff[i*COEF_W +: COEF_W];
         end else if (i < 2 * REG_COEFS) begin
            coefs[i] = coef_high_ff[(i-REG_COEFS)*COEF_W +: COEF_W];
         end else begin
            coefs[i] = '0;
         end
      end
   end

   // The whole pipeline moves together whenever the output register is free.
   assign ctrl.advance = !out_valid_ff || rsp_ready;
   assign ctrl.taps    = taps_eff;

   assign req_row[0] = req_lane_in_0;
   assign req_row[1] = req_lane_in_1;
   assign req_row[2] = req_lane_in_2;
   assign req_row[3] = req_lane_in_3;
   assign req_row[4] = req_lane_in_4;
   assign req_row[5] = req_lane_in_5;
   assign req_row[6] = req_lane_in_6;
   assign req_row[7] = req_lane_in_7;

   vsb_history u_history (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .req_valid    (req_valid),
      .req_row      (req_row),
      .req_last_row (req_last_row),
      .req_ready    (req_ready),
      .window       (window),
      .status       (status)
   );

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         for (int j = 0; j < WIN; j++) begin
            column[l][j] = window[j][l];
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      vsb_lane u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .column (column[l]),
         .coefs  (coefs),
         .result (lane_result[l])
      );
   end

   // Valid and end-of-column flags track the lane stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         va_ff        <= status.live;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         out_valid_ff <= vc_ff;
      end
   end

   // Merge stage: all lane results and the flag form one output word.
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         ea_ff      <= status.last;
         eb_ff      <= ea_ff;
         ec_ff      <= eb_ff;
         out_end_ff <= ec_ff;
         for (int l = 0; l < LANES; l++) begin
            out_ff[l] <= lane_result[l];
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_column_end = out_end_ff;
   assign rsp_lane_out_0 = out_ff[0];
   assign rsp_lane_out_1 = out_ff[1];
   assign rsp_lane_out_2 = out_ff[2];
   assign rsp_lane_out_3 = out_ff[3];
   assign rsp_lane_out_4 = out_ff[4];
   assign rsp_lane_out_5 = out_ff[5];
   assign rsp_lane_out_6 = out_ff[6];
   assign rsp_lane_out_7 = out_ff[7];

endmodule

`default_nettype wire

/* rtl/core/vsb_checker.sv */
// ----------------------------------------------------------------------------
// vsb_checker: port-level checks of the vertical symmetric blur
// Watches the handshakes and the flush behavior seen at the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vsb_checker
   import vsb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic                  req_last_row,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [OUT_W-1:0]      rsp_lane_out_0,
   input  wire logic [OUT_W-1:0]      rsp_lane_out_1,
   input  wire logic [OUT_W-1:0]      rsp_lane_out_2,
   input  wire logic [OUT_W-1:0]      rsp_lane_out_3,
   input  wire logic [OUT_W-1:0]      rsp_lane_out_4,
   input  wire logic [OUT_W-1:0]      rsp_lane_out_5,
   input  wire logic [OUT_W-1:0]      rsp_lane_out_6,
   input  wire logic [OUT_W-1:0]      rsp_lane_out_7,
   input  wire logic                  rsp_column_end
);

   // A stalled output word holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_lane_out_0) && $stable(rsp_lane_out_1)
         && $stable(rsp_lane_out_2) && $stable(rsp_lane_out_3)
         && $stable(rsp_lane_out_4) && $stable(rsp_lane_out_5)
         && $stable(rsp_lane_out_6) && $stable(rsp_lane_out_7)
         && $stable(rsp_column_end))
      else $error("output word changed while stalled");

   // The pipeline moves as one, so a stalled output also stops the input.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while the output is stalled");

   // The flush rows occupy the cycle after a last row is accepted.
   a_flush_blocks_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_row |=> !req_ready)
      else $error("input accepted right after a last row");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

endmodule

bind vertical_symmetric_blur vsb_checker u_vsb_checker (.*);

`default_nettype wire
